// ===== src/timed_setpoint_schedule_queue_macros.svh =====
// ---------------------------------------------------------------------------
// Setpoint schedule queue assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// during reset.
// ---------------------------------------------------------------------------
`ifndef TIMED_SETPOINT_SCHEDULE_QUEUE_MACROS_SVH
`define TIMED_SETPOINT_SCHEDULE_QUEUE_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define TSSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define TSSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tssq_pkg.sv =====
// ---------------------------------------------------------------------------
// Setpoint schedule queue package
// Types, codes and constants shared by the queue cells and the top level.
// ---------------------------------------------------------------------------
package tssq_pkg;

  localparam int STAGES_DEF = 16;
  localparam int TIME_W     = 32;
  localparam int MODE_W     = 3;
  localparam int TGT_W      = 32;
  localparam int HELD_W     = 5;
  localparam int TOL_W      = 8;
  localparam int OP_W       = 2;

  localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;
  localparam logic [TGT_W-1:0] LIM_MAX   = 32'h7FFF_FFFF;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_APPLY  = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  typedef logic [MODE_W-1:0] cmode_t;
  localparam cmode_t CM_PRESSURE = 3'd0;
  localparam cmode_t CM_OIL      = 3'd1;
  localparam cmode_t CM_WATER    = 3'd2;
  localparam cmode_t CM_LIQUID   = 3'd3;
  localparam cmode_t CM_GAS      = 3'd4;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  typedef struct packed {
    logic [TIME_W-1:0]       start;
    cmode_t                  mode;
    logic signed [TGT_W-1:0] target;
  } entry_t;

  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [TGT_W-1:0] pressure;
    logic signed [TGT_W-1:0] oil;
    logic signed [TGT_W-1:0] water;
    logic signed [TGT_W-1:0] liquid;
    logic signed [TGT_W-1:0] gas;
  } limits_t;

  function automatic logic signed [TGT_W-1:0] limit_of(input limits_t l, input cmode_t m);
    logic signed [TGT_W-1:0] v;
    case (m)
      CM_PRESSURE: v = l.pressure;
      CM_OIL:      v = l.oil;
      CM_WATER:    v = l.water;
      CM_LIQUID:   v = l.liquid;
      CM_GAS:      v = l.gas;
      default:     v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/tssq_cell.sv =====
// ---------------------------------------------------------------------------
// Setpoint schedule queue cell
// Holds one stage of the sorted table and trades entries with its neighbors
// on insert (shift toward the tail) and remove (shift toward the head).
// ---------------------------------------------------------------------------
module tssq_cell
  import tssq_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              occupied,
  input  logic [TIME_W-1:0] t_req,
  input  entry_t            new_entry,
  input  entry_t            left_entry,
  input  logic              left_goes,
  input  entry_t            right_entry,
  output entry_t            entry,
  output logic              goes_right,
  output logic              eq_hit
);

  entry_t ent_r, ent_nxt;

  // An empty cell, or one whose start lies after the new time, makes room.
  assign goes_right = !occupied || (t_req < ent_r.start);
  assign eq_hit     = occupied && (t_req == ent_r.start);
  assign entry      = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins_en && goes_right) begin
      ent_nxt = left_goes ? left_entry : new_entry;
    end else if (ctrl.pop_en) begin
      ent_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== src/timed_setpoint_schedule_queue.sv =====
// ---------------------------------------------------------------------------
// Timed setpoint schedule queue
// Time-sorted table of control stages built as a row of cells, with an
// apply/remove path on the head stage and the per-mode limit registers.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake            Contents
// in_      slave      in_tvalid/in_tready  tuser: op; tdata: stage or time
// out_     master     out_tvalid/out_tready tdata: status and limits
// cfg_     write      cfg_we               cfg_wdata: due_tolerance
//
// Each item passes through ST_IDLE, which captures the transfer, and ST_EXEC,
// in which every cell compares its start time and the table shifts. The output
// register is filled in ST_EXEC and is held until the result transfer; while
// it is still full the block stalls in ST_EXEC. Reset clears the stage
// count, mode, limits and tolerance; the cells need no clearing.
// ---------------------------------------------------------------------------
`include "timed_setpoint_schedule_queue_macros.svh"

module timed_setpoint_schedule_queue
  import tssq_pkg::*;
#(
  parameter int STAGES = STAGES_DEF
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // op
  input  logic [71:0]  in_tdata,   // time_req, control_mode, target, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  // done_res, table_full, stages_held, active_mode, applied_target,
  // pressure_limit, oil_limit, water_limit, liquid_limit, gas_limit, zero pad
  output logic [207:0] out_tdata,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata
);

  localparam int CNT_W = $clog2(STAGES + 1);

  state_t state_r, state_nxt;

  op_t                     op_r;
  logic [TIME_W-1:0]       t_r;
  cmode_t                  cm_r;
  logic signed [TGT_W-1:0] tg_r;
  entry_t                  new_entry;

  logic [CNT_W-1:0] count_r, count_nxt;
  cmode_t           cmode_r, cmode_nxt;
  limits_t          lim_r, lim_nxt;
  logic [TOL_W-1:0] tol_r;

  logic         out_valid_r;
  logic [207:0] out_data_r, out_data_nxt;

  entry_t           ent [STAGES];
  logic [STAGES-1:0] goes;
  logic [STAGES-1:0] eq;
  logic [STAGES-1:0] occ;
  cell_ctrl_t       ctrl;

  logic                dup, full, due, ins_ok, apply_ok, pop_ok, commit;
  logic [CNT_W+4:0]    held_ext;
  logic [TIME_W:0]     due_sum;

  // Cell chain
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    entry_t l_ent, r_ent;
    logic   l_goes;
    if (i == 0) begin : g_first
      assign l_ent  = new_entry;
      assign l_goes = 1'b0;
    end else begin : g_mid
      assign l_ent  = ent[i-1];
      assign l_goes = goes[i-1];
    end
    if (i == STAGES - 1) begin : g_last
      assign r_ent = new_entry;
    end else begin : g_inner
      assign r_ent = ent[i+1];
    end
    assign occ[i] = CNT_W'(i) < count_r;

    tssq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ[i]),
      .t_req       (t_r),
      .new_entry   (new_entry),
      .left_entry  (l_ent),
      .left_goes   (l_goes),
      .right_entry (r_ent),
      .entry       (ent[i]),
      .goes_right  (goes[i]),
      .eq_hit      (eq[i])
    );
  end

  assign new_entry = '{start: t_r, mode: cm_r, target: tg_r};

  // Item decode
  assign dup      = |eq;
  assign full     = count_r == CNT_W'(STAGES);
  assign due_sum  = {1'b0, t_r} + (TIME_W + 1)'(tol_r);
  assign due      = (count_r != '0) && (due_sum >= {1'b0, ent[0].start});
  assign ins_ok   = (op_r == OP_INSERT) && !dup && !full;
  assign apply_ok = (op_r == OP_APPLY) && due;
  assign pop_ok   = (op_r == OP_REMOVE) && due;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_tready) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ctrl.ins_en = commit && ins_ok;
  assign ctrl.pop_en = commit && pop_ok;

  always_comb begin
    count_nxt = count_r;
    cmode_nxt = cmode_r;
    lim_nxt   = lim_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (apply_ok) begin
      cmode_nxt = ent[0].mode;
      case (ent[0].mode)
        CM_PRESSURE: lim_nxt.pressure = ent[0].target;
        CM_OIL:      lim_nxt.oil      = ent[0].target;
        CM_WATER:    lim_nxt.water    = ent[0].target;
        CM_LIQUID:   lim_nxt.liquid   = ent[0].target;
        CM_GAS:      lim_nxt.gas      = ent[0].target;
        default:     lim_nxt          = lim_r;
      endcase
    end
  end

  // The result count is reported modulo 32.
  assign held_ext = {5'b0, count_nxt};

  always_comb begin
    out_data_nxt          = '0;
    out_data_nxt[0]       = ins_ok || apply_ok || pop_ok;
    out_data_nxt[1]       = (op_r == OP_INSERT) && !dup && full;
    out_data_nxt[6:2]     = held_ext[HELD_W-1:0];
    out_data_nxt[9:7]     = cmode_nxt;
    out_data_nxt[41:10]   = limit_of(lim_nxt, cmode_nxt);
    out_data_nxt[73:42]   = lim_nxt.pressure;
    out_data_nxt[105:74]  = lim_nxt.oil;
    out_data_nxt[137:106] = lim_nxt.water;
    out_data_nxt[169:138] = lim_nxt.liquid;
    out_data_nxt[201:170] = lim_nxt.gas;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmode_r     <= CM_PRESSURE;
      lim_r       <= '{pressure: '0, oil: LIM_MAX, water: LIM_MAX,
                       liquid: LIM_MAX, gas: LIM_MAX};
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (commit) begin
        count_r     <= count_nxt;
        cmode_r     <= cmode_nxt;
        lim_r       <= lim_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r <= in_tuser;
      t_r  <= in_tdata[31:0];
      cm_r <= in_tdata[34:32];
      tg_r <= in_tdata[66:35];
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TSSQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(STAGES),
    "stage count past depth")
  `TSSQ_ASSERT_NEXT(a_ins_count, clk, rst_n, ctrl.ins_en,
    count_r == $past(count_r) + CNT_W'(1), "insert did not grow count")
  `TSSQ_ASSERT_NEXT(a_pop_count, clk, rst_n, ctrl.pop_en,
    count_r == $past(count_r) - CNT_W'(1), "remove did not shrink count")
  `TSSQ_ASSERT(a_full_not_done, clk, rst_n,
    !(out_valid_r && out_data_r[0] && out_data_r[1]), "dropped insert reported done")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Setpoint schedule queue testbench
// Drives insert, apply and remove transfers into the schedule queue and
// checks every result field against a cycle-free predictor of the sorted
// stage table, the active mode and the five limits. A short directed table
// comes first, then random phases with changing tolerance and back-pressure.
// ---------------------------------------------------------------------------
module tb_top;
  import tssq_pkg::*;

  localparam int DEPTH       = STAGES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_WAIT = 4;

  localparam op_t    OP_NONE   = 2'd3;
  localparam cmode_t CM_SPARE5 = 3'd5;
  localparam cmode_t CM_SPARE6 = 3'd6;
  localparam cmode_t CM_SPARE7 = 3'd7;

  // Result fields, in the order they are packed into out_tdata.
  localparam int F_DONE    = 0;
  localparam int F_FULL    = 1;
  localparam int F_HELD    = 2;
  localparam int F_MODE    = 3;
  localparam int F_APPLIED = 4;
  localparam int F_LIM0    = 5;
  localparam int N_FIELDS  = 10;

  typedef logic [N_FIELDS-1:0][31:0] res_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] t;
    cmode_t      cm;
    logic [31:0] tg;
    logic        known;
    logic        e_done;
    logic        e_full;
    logic [4:0]  e_held;
    cmode_t      e_mode;
    logic [31:0] e_applied;
  } plan_row_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser   = '0;
  logic [71:0]  in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [207:0] out_tdata;
  logic         cfg_we     = 1'b0;
  logic [7:0]   cfg_wdata  = '0;

  timed_setpoint_schedule_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predicted state of the stage table and the limits.
  logic [31:0] sched_start [DEPTH];
  cmode_t      sched_mode  [DEPTH];
  logic [31:0] sched_tgt   [DEPTH];
  int          sched_cnt;
  cmode_t      act_mode;
  logic [31:0] lim [5];
  logic [7:0]  tol;

  res_t        exp_q [$];
  int          err_cnt       = 0;
  int          cycle_cnt     = 0;
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int          hold_left     = 0;
  logic [31:0] cur_time      = '0;

  string field_name [N_FIELDS] = '{"done_res", "table_full", "stages_held",
    "active_mode", "applied_target", "pressure_limit", "oil_limit",
    "water_limit", "liquid_limit", "gas_limit"};

  plan_row_t directed_rows [25] = '{
    '{OP_APPLY,  32'h0000_0000, CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd0,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_REMOVE, 32'hFFFF_FFFF, CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd0,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_NONE,   32'h0000_0005, CM_SPARE7,   32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 5'd0,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_INSERT, 32'd100,       CM_OIL,      32'h1234_5678, 1'b1, 1'b1, 1'b0, 5'd1,
      CM_PRESSURE, 32'h0000_0000},
    // Same start time again: dropped without the full flag.
    '{OP_INSERT, 32'd100,       CM_WATER,    32'h0000_0001, 1'b1, 1'b0, 1'b0, 5'd1,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_APPLY,  32'd98,        CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd1,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_APPLY,  32'd99,        CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd1,
      CM_OIL,      32'h1234_5678},
    '{OP_INSERT, 32'h0000_0000, CM_GAS,      32'h8000_0000, 1'b1, 1'b1, 1'b0, 5'd2,
      CM_OIL,      32'h1234_5678},
    '{OP_APPLY,  32'h0000_0000, CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd2,
      CM_GAS,      32'h8000_0000},
    '{OP_REMOVE, 32'h0000_0000, CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd1,
      CM_GAS,      32'h8000_0000},
    '{OP_INSERT, 32'hFFFF_FFFF, CM_SPARE7,   32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, 5'd2,
      CM_GAS,      32'h8000_0000},
    '{OP_INSERT, 32'd50,        CM_SPARE5,   32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 5'd3,
      CM_GAS,      32'h8000_0000},
    // A stage with an unused mode code switches the mode but sets no limit.
    '{OP_APPLY,  32'd49,        CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd3,
      CM_SPARE5,   32'h0000_0000},
    '{OP_REMOVE, 32'd49,        CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd2,
      CM_SPARE5,   32'h0000_0000},
    '{OP_REMOVE, 32'd50,        CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd2,
      CM_SPARE5,   32'h0000_0000},
    '{OP_APPLY,  32'hFFFF_FFFF, CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd2,
      CM_OIL,      32'h1234_5678},
    '{OP_REMOVE, 32'hFFFF_FFFF, CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd1,
      CM_OIL,      32'h1234_5678},
    // The due sum must not wrap at the top of the time range.
    '{OP_REMOVE, 32'hFFFF_FFFE, CM_PRESSURE, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 5'd0,
      CM_OIL,      32'h1234_5678},
    '{OP_INSERT, 32'd200,       CM_LIQUID,   32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0, 5'd0,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_INSERT, 32'd300,       CM_SPARE6,   32'h0000_0000, 1'b0, 1'b0, 1'b0, 5'd0,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_INSERT, 32'd400,       CM_PRESSURE, 32'h0000_0100, 1'b0, 1'b0, 1'b0, 5'd0,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_APPLY,  32'd250,       CM_PRESSURE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 5'd0,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_REMOVE, 32'd250,       CM_PRESSURE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 5'd0,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_APPLY,  32'd300,       CM_PRESSURE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 5'd0,
      CM_PRESSURE, 32'h0000_0000},
    '{OP_NONE,   32'hFFFF_FFFF, CM_SPARE7,   32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 5'd0,
      CM_PRESSURE, 32'h0000_0000}
  };

  function automatic void clear_schedule();
    sched_cnt = 0;
    act_mode  = CM_PRESSURE;
    lim[CM_PRESSURE] = '0;
    lim[CM_OIL]      = LIM_MAX;
    lim[CM_WATER]    = LIM_MAX;
    lim[CM_LIQUID]   = LIM_MAX;
    lim[CM_GAS]      = LIM_MAX;
    tol = TOL_RESET;
  endfunction

  // Applies one item to the predicted table and returns the result it gives.
  function automatic res_t step_schedule(op_t op, logic [31:0] t, cmode_t cm,
                                         logic [31:0] tg);
    res_t r;
    int   pos;
    bit   dup;
    bit   due;
    r   = '0;
    due = (sched_cnt != 0) && (({1'b0, t} + 33'(tol)) >= {1'b0, sched_start[0]});
    case (op)
      OP_INSERT: begin
        pos = 0;
        while (pos < sched_cnt && t > sched_start[pos]) pos++;
        dup = (pos < sched_cnt) && (t == sched_start[pos]);
        if (!dup) begin
          if (sched_cnt >= DEPTH) begin
            r[F_FULL] = 1;
          end else begin
            for (int i = sched_cnt; i > pos; i--) begin
              sched_start[i] = sched_start[i-1];
              sched_mode[i]  = sched_mode[i-1];
              sched_tgt[i]   = sched_tgt[i-1];
            end
            sched_start[pos] = t;
            sched_mode[pos]  = cm;
            sched_tgt[pos]   = tg;
            sched_cnt++;
            r[F_DONE] = 1;
          end
        end
      end
      OP_APPLY: begin
        if (due) begin
          act_mode = sched_mode[0];
          if (act_mode <= CM_GAS) lim[act_mode] = sched_tgt[0];
          r[F_DONE] = 1;
        end
      end
      OP_REMOVE: begin
        if (due) begin
          for (int i = 1; i < sched_cnt; i++) begin
            sched_start[i-1] = sched_start[i];
            sched_mode[i-1]  = sched_mode[i];
            sched_tgt[i-1]   = sched_tgt[i];
          end
          sched_cnt--;
          r[F_DONE] = 1;
        end
      end
      default: ;
    endcase
    r[F_HELD]    = 32'(sched_cnt & 31);
    r[F_MODE]    = 32'(act_mode);
    r[F_APPLIED] = (act_mode <= CM_GAS) ? lim[act_mode] : '0;
    for (int k = 0; k < 5; k++) r[F_LIM0+k] = lim[k];
    return r;
  endfunction

  // Offers one item, waits for its transfer and queues its expected result.
  task automatic send_item(op_t op, logic [31:0] t, cmode_t cm, logic [31:0] tg);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, tg, cm, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp_q.insert(exp_q.size(), step_schedule(op, t, cm, tg));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tol = v;
  endtask

  function automatic cmode_t pick_mode();
    if ($urandom_range(0, 9) == 0) return cmode_t'($urandom_range(5, 7));
    return cmode_t'($urandom_range(0, 4));
  endfunction

  // Mostly well-formed traffic around a slowly advancing clock, so stages
  // become due and the table both fills and drains; a few wild times and
  // unused mode codes are mixed in.
  task automatic send_random_item();
    int          r;
    op_t         op;
    logic [31:0] t;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      op = OP_INSERT;
      t  = cur_time + 32'($urandom_range(0, 60));
      if ($urandom_range(0, 19) == 0) t = $urandom;
    end else if (r < 93) begin
      op = (r < 65) ? OP_APPLY : OP_REMOVE;
      t  = cur_time + 32'($urandom_range(0, 30));
    end else if (r < 96) begin
      op = OP_NONE;
      t  = $urandom;
    end else begin
      op = $urandom_range(0, 1) ? OP_APPLY : OP_REMOVE;
      t  = $urandom;
    end
    send_item(op, t, pick_mode(), $urandom);
    cur_time = cur_time + 32'($urandom_range(0, 6));
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got[F_DONE]    = 32'(out_tdata[0]);
      got[F_FULL]    = 32'(out_tdata[1]);
      got[F_HELD]    = 32'(out_tdata[6:2]);
      got[F_MODE]    = 32'(out_tdata[9:7]);
      got[F_APPLIED] = out_tdata[41:10];
      for (int k = 0; k < 5; k++) got[F_LIM0+k] = out_tdata[42+32*k +: 32];
      if (exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("[%0t] result transfer with no item pending", $realtime);
      end else begin
        want = exp_q.pop_front();
        for (int k = 0; k < N_FIELDS; k++) begin
          if (got[k] !== want[k]) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("[%0t] %s mismatch: expected %h, got %h", $realtime,
                       field_name[k], want[k], got[k]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    plan_row_t row;
    clear_schedule();
    src_idle_pct  = 29;
    sink_idle_pct = 75;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows run with the tolerance left by reset.
    for (int i = 0; i < 25; i++) begin
      row = directed_rows[i];
      send_item(row.op, row.t, row.cm, row.tg);
      if (row.known) begin
        exp_q[exp_q.size()-1][F_DONE]    = 32'(row.e_done);
        exp_q[exp_q.size()-1][F_FULL]    = 32'(row.e_full);
        exp_q[exp_q.size()-1][F_HELD]    = 32'(row.e_held);
        exp_q[exp_q.size()-1][F_MODE]    = 32'(row.e_mode);
        exp_q[exp_q.size()-1][F_APPLIED] = row.e_applied;
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: write_tolerance(8'd0);
        1: write_tolerance(8'd255);
        2: write_tolerance(8'($urandom_range(2, 254)));
        3: write_tolerance(8'd1);
        4: write_tolerance(8'($urandom_range(0, 255)));
        default: write_tolerance(8'd0);
      endcase
      case (p / 2)
        0: begin
          src_idle_pct  = 29;
          sink_idle_pct = 75;
        end
        1: begin
          src_idle_pct  = 75;
          sink_idle_pct = 29;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      // Long receiver stall while the sender keeps pushing.
      if (p == 4) hold_req = 1'b1;
      cur_time = (p == 3) ? 32'hFFFF_F000 : $urandom;
      // Open each phase with a run of inserts that reaches a full table.
      for (int k = 0; k < DEPTH + 1; k++)
        send_item(OP_INSERT, cur_time + 32'(3 * k), pick_mode(), $urandom);
      for (int k = 0; k < 190; k++) send_random_item();
    end

    settle();
    if (err_cnt == 0 && exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
